// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the hasher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ----- hdl/sha1_pkg.sv -----
// Package with SHA-1 constants, types and round helpers.
`timescale 1ns / 1ps
`default_nettype none
package sha1_pkg;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LenLimit = BlockBytes - 8;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [7:0] PadMark = 8'h80;
	localparam logic FuncAbsorb = 1'b0;
	localparam logic FuncFinish = 1'b1;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} out_item_t;

	typedef struct packed {
		logic func;
		logic [7:0] data_byte;
	} in_item_t;

	// Control from the sequencer to the round core.
	typedef struct packed {
		logic start;
		logic init;
	} core_ctl_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] init_word(input logic [2:0] i);
		case (i)
			3'd0: init_word = H0;
			3'd1: init_word = H1;
			3'd2: init_word = H2;
			3'd3: init_word = H3;
			default: init_word = H4;
		endcase
	endfunction
endpackage
`default_nettype wire

// ----- hdl/sha1_if.sv -----
// Valid/ready channel interface carrying one payload item.
`timescale 1ns / 1ps
`default_nettype none
interface sha1_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/sha1_message_hasher_unit.sv -----
// SHA-1 streaming hasher top level: byte packing, padding and digest output.
// Absorb: one byte per cycle while the core is idle; a full block then runs 80 rounds, each a
// read and a round phase, and no byte is taken until they finish. Finish: 16-word pad sweep
// and compression, plus a length sweep and compression when the length does not fit, then output.
// Throughput set by the round core reading its schedule memory once per round.
// Reset (arst_n low) restores the initial chaining value and clears all counters at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha1_message_hasher_unit (
	input wire logic clk,
	input wire logic arst_n,
	sha1_if.sink in_ch,
	sha1_if.source out_ch
);
	import sha1_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StRun = 3'd1;
	localparam logic [2:0] StPad = 3'd2;
	localparam logic [2:0] StPadRun = 3'd3;
	localparam logic [2:0] StLen = 3'd4;
	localparam logic [2:0] StLenRun = 3'd5;
	localparam logic [2:0] StOut = 3'd6;

	logic [2:0] st_q;
	logic [5:0] fill_q;
	logic [60:0] total_q;
	logic [23:0] part_q;
	logic [3:0] pw_q;
	logic [2:0] oi_q;
	logic ovalid_q;
	logic last_blk_q;
	logic core_busy, start_d;
	core_ctl_t ctl;
	logic wr_en;
	logic [3:0] wr_addr;
	logic [31:0] wr_data, h_word, pad_word;
	logic [63:0] bits;
	in_item_t it;
	logic acc;

	assign it = in_ch.payload;
	assign acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == StIdle) && !core_busy && !start_d;
	assign bits = {total_q, 3'b000};

	// Padding word at pw_q: partial bytes, marker, zeros, length on the last two of the final block.
	always_comb begin
		logic [31:0] base;
		base = '0;
		if (pw_q == fill_q[5:2]) begin
			case (fill_q[1:0])
				2'd0: base = {PadMark, 24'd0};
				2'd1: base = {part_q[7:0], PadMark, 16'd0};
				2'd2: base = {part_q[15:0], PadMark, 8'd0};
				default: base = {part_q, PadMark};
			endcase
		end
		pad_word = base;
		if (last_blk_q && pw_q == 4'd14) pad_word = bits[63:32];
		if (last_blk_q && pw_q == 4'd15) pad_word = bits[31:0];
	end

	// Write each packed message word; the pad sweep fills from the fill word up, the length sweep all.
	always_comb begin
		wr_en = 1'b0; wr_addr = fill_q[5:2]; wr_data = {part_q, it.data_byte};
		if (acc && it.func == FuncAbsorb && fill_q[1:0] == 2'd3) wr_en = 1'b1;
		if (st_q == StLen || (st_q == StPad && pw_q >= fill_q[5:2])) begin
			wr_en = 1'b1; wr_addr = pw_q; wr_data = pad_word;
		end
	end

	assign ctl.init = ovalid_q && out_ch.ready && oi_q == 3'd4;
	assign ctl.start = start_d;

	sha1_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data(wr_data), .busy(core_busy), .h_sel(oi_q), .h_word(h_word)
	);

	// Sequence absorb, pad sweeps, compressions and output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle; fill_q <= '0; total_q <= '0; pw_q <= '0;
			oi_q <= '0; ovalid_q <= 1'b0; start_d <= 1'b0; last_blk_q <= 1'b0;
		end else begin
			start_d <= 1'b0;
			case (st_q)
				StIdle: begin
					if (acc && it.func == FuncAbsorb) begin
						part_q <= {part_q[15:0], it.data_byte};
						fill_q <= fill_q + 6'd1;
						total_q <= total_q + 61'd1;
						if (fill_q == 6'd63) begin
							start_d <= 1'b1; st_q <= StRun;
						end
					end else if (acc) begin
						pw_q <= '0;
						last_blk_q <= ({1'b0, fill_q} + 7'd1 <= 7'(LenLimit));
						st_q <= StPad;
					end
				end
				StRun: if (!core_busy && !start_d) st_q <= StIdle;
				StPad, StLen: begin
					pw_q <= pw_q + 4'd1;
					if (pw_q == 4'd15) begin
						start_d <= 1'b1;
						st_q <= (st_q == StPad) ? StPadRun : StLenRun;
					end
				end
				StPadRun: begin
					if (!core_busy && !start_d) begin
						if (last_blk_q) begin
							st_q <= StOut; ovalid_q <= 1'b1; oi_q <= '0;
						end else begin
							// second block: all zeros plus length
							last_blk_q <= 1'b1; fill_q <= 6'd63; pw_q <= '0;
							st_q <= StLen;
						end
					end
				end
				StLenRun: begin
					if (!core_busy && !start_d) begin
						st_q <= StOut; ovalid_q <= 1'b1; oi_q <= '0;
					end
				end
				default: begin
					if (out_ch.ready) begin
						if (oi_q == 3'd4) begin
							ovalid_q <= 1'b0; st_q <= StIdle;
							fill_q <= '0; total_q <= '0;
						end else begin
							oi_q <= oi_q + 3'd1;
						end
					end
				end
			endcase
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.payload = '{digest_word: h_word, word_index: oi_q,
		last_word: (oi_q == 3'd4)};

	`ASSERT_IMPL(a_out_idx, clk, arst_n, ovalid_q, oi_q < 3'd5)
	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ch.ready, !ovalid_q)
	`ASSERT_NEXT(a_full_run, clk, arst_n, acc && it.func == FuncAbsorb && fill_q == 6'd63,
		st_q == StRun)
endmodule
`default_nettype wire

// ----- hdl/sha1_core.sv -----
// SHA-1 round core: 80 rounds over a 16-word schedule memory.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha1_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire sha1_pkg::core_ctl_t ctl,
	// schedule memory write port from the block buffer side
	input wire logic wr_en,
	input wire logic [3:0] wr_addr,
	input wire logic [31:0] wr_data,
	output logic busy,
	input wire logic [2:0] h_sel,
	output logic [31:0] h_word
);
	import sha1_pkg::*;

	logic [31:0] wmem [16];
	logic [31:0] rd_q [4];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] h_q [5];
	logic [6:0] rnd_q;
	logic [1:0] ph_q;
	logic [31:0] wt, f, k, t;
	logic [3:0] ra [4];
	logic [3:0] ridx;

	// phases: each round is a read then a round phase; an add phase follows the last round
	localparam logic [1:0] PhIdle = 2'd0;
	localparam logic [1:0] PhRead = 2'd1;
	localparam logic [1:0] PhRound = 2'd2;
	localparam logic [1:0] PhAdd = 2'd3;

	assign busy = (ph_q != PhIdle);
	assign ridx = rnd_q[3:0];
	assign ra[0] = ridx;
	assign ra[1] = ridx + 4'd2;
	assign ra[2] = ridx + 4'd8;
	assign ra[3] = ridx + 4'd13;

	// Read the four schedule taps, registered; write loaded words while idle and each new W in the round phase.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			rd_q[i] <= wmem[ra[i]];
		end
		if (wr_en && !busy) begin
			wmem[wr_addr] <= wr_data;
		end else if (ph_q == PhRound) begin
			wmem[ridx] <= wt;
		end
	end

	always_comb begin
		if (rnd_q < 7'd16) begin
			wt = rd_q[0];
		end else begin
			wt = rotl(rd_q[0] ^ rd_q[1] ^ rd_q[2] ^ rd_q[3], 1);
		end
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5a827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ed9eba1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8f1bbcdc;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hca62c1d6;
		end
		t = rotl(a_q, 5) + f + e_q + k + wt;
	end

	// Sequence rounds and fold into the chaining value; init restores the initial value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PhIdle;
			rnd_q <= '0;
			for (int i = 0; i < 5; i++) h_q[i] <= init_word(3'(i));
		end else begin
			case (ph_q)
				PhIdle: begin
					if (ctl.init) begin
						for (int i = 0; i < 5; i++) h_q[i] <= init_word(3'(i));
					end else if (ctl.start) begin
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
						d_q <= h_q[3]; e_q <= h_q[4];
						rnd_q <= '0;
						ph_q <= PhRead;
					end
				end
				PhRead: ph_q <= PhRound;
				PhRound: begin
					e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 30);
					b_q <= a_q; a_q <= t;
					if (rnd_q == 7'd79) begin
						ph_q <= PhAdd;
					end else begin
						rnd_q <= rnd_q + 7'd1;
						ph_q <= PhRead;
					end
				end
				default: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					ph_q <= PhIdle;
				end
			endcase
		end
	end

	assign h_word = (h_sel < 3'd5) ? h_q[h_sel] : h_q[0];

	`ASSERT_IMPL(a_rnd_range, clk, arst_n, busy, rnd_q < 7'd80)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, !busy && ctl.start && !ctl.init, busy)
	`ASSERT_NEXT(a_add_idle, clk, arst_n, ph_q == PhAdd, !busy)
endmodule
`default_nettype wire
